[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SMOM_ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("same-cycle implication failed");
`define SMOM_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("next-cycle implication failed");
`else
`define SMOM_ASSERT_IMPL(lbl, ant, con)
`define SMOM_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

[sv/smom_pkg.sv]
// types and constants for the scalar multiplier modulo the secp256k1 order
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package smom_pkg;

  localparam int DIG_W   = 32;
  localparam int N_DIG   = 8;
  localparam int OPND_W  = DIG_W * N_DIG;
  localparam int PROD_W  = 2 * OPND_W;
  localparam int SHIFT_W = 128;

  localparam logic OP_MOD   = 1'b0;
  localparam logic OP_SHIFT = 1'b1;

  // group order n and c = 2^256 - n
  localparam logic [OPND_W-1:0] ORDER_N =
    256'hFFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFE_BAAEDCE6AF48A03B_BFD25E8CD0364141;
  localparam logic [OPND_W-1:0] ORDER_C =
    256'h0000000000000000_0000000000000001_4551231950B75FC4_402DA1732FC9BEBF;

  typedef struct packed {
    logic        opcode;
    logic [63:0] a_word0;
    logic [63:0] a_word1;
    logic [63:0] a_word2;
    logic [63:0] a_word3;
    logic [63:0] b_word0;
    logic [63:0] b_word1;
    logic [63:0] b_word2;
    logic [63:0] b_word3;
  } in_t;

  typedef struct packed {
    logic [63:0] r_word3;
    logic [63:0] r_word2;
    logic [63:0] r_word1;
    logic [63:0] r_word0;
  } out_t;

  typedef struct packed {
    logic               opcode;
    logic [SHIFT_W-1:0] shifted;
  } side_t;

endpackage

`default_nettype wire

[sv/smom_mac.sv]
// pipelined 256 x 256 multiply with 256-bit addend, six register stages
// depends on smom_pkg
`timescale 1ns / 1ps
`default_nettype none

module smom_mac (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [smom_pkg::OPND_W-1:0]   x,
  input  wire logic [smom_pkg::OPND_W-1:0]   y,
  input  wire logic [smom_pkg::OPND_W-1:0]   z,
  input  wire smom_pkg::side_t               in_side,
  output logic                               out_valid,
  output logic [smom_pkg::PROD_W-1:0]        out_r,
  output smom_pkg::side_t                    out_side
);

  localparam int ND = smom_pkg::N_DIG;
  localparam int DW = smom_pkg::DIG_W;
  localparam int PW = smom_pkg::PROD_W;

  logic [5:0]            vld_r;
  smom_pkg::side_t       sd_r [6];

  logic [2*DW-1:0]       pp_nxt [ND*ND];
  logic [2*DW-1:0]       pp_r   [ND*ND];
  logic [smom_pkg::OPND_W-1:0] z1_r;

  logic [PW-1:0]         vec   [2*ND+1];
  logic [PW-1:0]         s2_nxt [9];
  logic [PW-1:0]         s2_r  [9];
  logic [PW-1:0]         s3_r  [5];
  logic [PW-1:0]         s4_r  [3];
  logic [PW-1:0]         s5_r  [2];
  logic [PW-1:0]         r_r;

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      for (int j = 0; j < ND; j++) begin
        pp_nxt[i*ND+j] = (2*DW)'(x[DW*i +: DW]) * (2*DW)'(y[DW*j +: DW]);
      end
    end
  end

  // even and odd digit rows hold non-overlapping partial products
  always_comb begin
    for (int k = 0; k < 2*ND+1; k++) begin
      vec[k] = '0;
    end
    for (int i = 0; i < ND; i++) begin
      for (int j = 0; j < ND; j++) begin
        if ((j % 2) == 0) begin
          vec[2*i][DW*(i+j) +: 2*DW] = pp_r[i*ND+j];
        end else begin
          vec[2*i+1][DW*(i+j) +: 2*DW] = pp_r[i*ND+j];
        end
      end
    end
    vec[2*ND] = PW'(z1_r);
    for (int k = 0; k < 8; k++) begin
      s2_nxt[k] = vec[2*k] + vec[2*k+1];
    end
    s2_nxt[8] = vec[16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r  <= pp_nxt;
      z1_r  <= z;
      sd_r[0] <= in_side;
      for (int k = 1; k < 6; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
      s2_r <= s2_nxt;
      for (int k = 0; k < 4; k++) begin
        s3_r[k] <= s2_r[2*k] + s2_r[2*k+1];
      end
      s3_r[4] <= s2_r[8];
      s4_r[0] <= s3_r[0] + s3_r[1];
      s4_r[1] <= s3_r[2] + s3_r[3];
      s4_r[2] <= s3_r[4];
      s5_r[0] <= s4_r[0] + s4_r[1];
      s5_r[1] <= s4_r[2];
      r_r     <= s5_r[0] + s5_r[1];
    end
  end

  assign out_valid = vld_r[5];
  assign out_r     = r_r;
  assign out_side  = sd_r[5];

endmodule

`default_nettype wire

[sv/scalar_mod_order_multiplier_top.sv]
// top level: 256-bit scalar product mod secp256k1 order or rounded >> 384
// depends on smom_pkg, smom_mac and assert_macros.svh
//
//  channel  ports                           direction  payload
//  input    in_valid in_ready in_data       in         smom_pkg::in_t
//  result   out_valid out_ready out_data    out        smom_pkg::out_t
//
// one transaction per cycle while the output is not stalled: product mac, three folds
// by c = 2^256 - n (six stages each) and one final compare-subtract stage
// the whole pipeline advances when the output register is empty or taken
// reset clears the valid bits only; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scalar_mod_order_multiplier_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire smom_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output smom_pkg::out_t       out_data
);

  localparam int OW = smom_pkg::OPND_W;
  localparam int PW = smom_pkg::PROD_W;
  localparam int SW = smom_pkg::SHIFT_W;

  logic                 adv;
  logic [3:0]           v;
  logic [PW-1:0]        r [4];
  smom_pkg::side_t      sd [4];
  smom_pkg::side_t      side0;
  smom_pkg::side_t      side1;
  logic [OW-1:0]        a_op;
  logic [OW-1:0]        b_op;

  logic [OW:0]          fin_v;
  logic [OW:0]          fin_d;
  logic [OW-1:0]        fin_res;
  smom_pkg::out_t       out_nxt;

  logic                 out_valid_r;
  logic                 out_op_r;
  smom_pkg::out_t       out_data_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign a_op = {in_data.a_word3, in_data.a_word2, in_data.a_word1, in_data.a_word0};
  assign b_op = {in_data.b_word3, in_data.b_word2, in_data.b_word1, in_data.b_word0};

  always_comb begin
    side0.opcode  = in_data.opcode;
    side0.shifted = '0;
    side1.opcode  = sd[0].opcode;
    side1.shifted = r[0][PW-1 -: SW] + SW'(r[0][PW-SW-1]);
  end

  smom_mac u_mul (
    .clk, .rst_n, .en(adv), .in_valid(in_valid),
    .x(a_op), .y(b_op), .z('0), .in_side(side0),
    .out_valid(v[0]), .out_r(r[0]), .out_side(sd[0])
  );

  smom_mac u_fold1 (
    .clk, .rst_n, .en(adv), .in_valid(v[0]),
    .x(r[0][PW-1:OW]), .y(smom_pkg::ORDER_C), .z(r[0][OW-1:0]), .in_side(side1),
    .out_valid(v[1]), .out_r(r[1]), .out_side(sd[1])
  );

  smom_mac u_fold2 (
    .clk, .rst_n, .en(adv), .in_valid(v[1]),
    .x(r[1][PW-1:OW]), .y(smom_pkg::ORDER_C), .z(r[1][OW-1:0]), .in_side(sd[1]),
    .out_valid(v[2]), .out_r(r[2]), .out_side(sd[2])
  );

  smom_mac u_fold3 (
    .clk, .rst_n, .en(adv), .in_valid(v[2]),
    .x(r[2][PW-1:OW]), .y(smom_pkg::ORDER_C), .z(r[2][OW-1:0]), .in_side(sd[2]),
    .out_valid(v[3]), .out_r(r[3]), .out_side(sd[3])
  );

  always_comb begin
    fin_v   = r[3][OW:0];
    fin_d   = fin_v - {1'b0, smom_pkg::ORDER_N};
    fin_res = (fin_v >= {1'b0, smom_pkg::ORDER_N}) ? fin_d[OW-1:0] : fin_v[OW-1:0];
    if (sd[3].opcode == smom_pkg::OP_SHIFT) begin
      out_nxt.r_word0 = sd[3].shifted[63:0];
      out_nxt.r_word1 = sd[3].shifted[127:64];
      out_nxt.r_word2 = '0;
      out_nxt.r_word3 = '0;
    end else begin
      out_nxt.r_word0 = fin_res[63:0];
      out_nxt.r_word1 = fin_res[127:64];
      out_nxt.r_word2 = fin_res[191:128];
      out_nxt.r_word3 = fin_res[255:192];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
      out_op_r   <= sd[3].opcode;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SMOM_ASSERT_IMPL(a_shift_upper_zero, out_valid_r && (out_op_r == smom_pkg::OP_SHIFT), (out_data_r.r_word2 == 64'd0) && (out_data_r.r_word3 == 64'd0))
  `SMOM_ASSERT_IMPL(a_mod_below_n, out_valid_r && (out_op_r == smom_pkg::OP_MOD), {out_data_r.r_word3, out_data_r.r_word2, out_data_r.r_word1, out_data_r.r_word0} < smom_pkg::ORDER_N)
  `SMOM_ASSERT_IMPL(a_fold_bound, v[3], r[3][PW-1:OW+1] == '0)
  `SMOM_ASSERT_NEXT(a_no_invented, !out_valid_r && !v[3], !out_valid_r)

endmodule

`default_nettype wire
